// File: hw/rtl/waveform_minmax_decimator_assert.svh
// ----------------------------------------------------------------------------
// waveform_minmax_decimator assertion macros
// concurrent check helpers clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_MINMAX_DECIMATOR_ASSERT_SVH
`define WAVEFORM_MINMAX_DECIMATOR_ASSERT_SVH

`ifndef SYNTHESIS

// plain invariant, checked at every edge
`define WMD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("wmd invariant violated");

// same-cycle implication
`define WMD_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wmd implication violated");

// next-cycle implication
`define WMD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wmd next-cycle check violated");

`else

`define WMD_ASSERT(lbl, prop)
`define WMD_ASSERT_IMPLY(lbl, ante, cons)
`define WMD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hw/rtl/wmd_pkg.sv
// ----------------------------------------------------------------------------
// wmd_pkg
// shared constants, point type and scaling functions of the min/max decimator
// ----------------------------------------------------------------------------
`default_nettype none

package wmd_pkg;

	localparam int INDEX_BITS = 24;
	localparam int SAMPLE_W   = 16;
	localparam int SEG_W      = 16;
	localparam int SCALE_W    = 44;
	localparam int SCALE_FRAC = 32;
	localparam int HEIGHT_W   = 12;
	localparam int X_W        = 16;
	localparam int Y_W        = 12;
	localparam int Y_SHIFT    = 16;
	localparam int YPROD_W    = SAMPLE_W + HEIGHT_W + 1;
	localparam int HIPROD_W   = INDEX_BITS + SCALE_W - SCALE_FRAC;

	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = SCALE_W;

	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLOT_HEIGHT = 2'd2;

	localparam logic [SEG_W-1:0]    SEG_LEN_RESET = 16'd1;
	localparam logic [SCALE_W-1:0]  X_SCALE_RESET = SCALE_W'(64'd1 << SCALE_FRAC);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = 12'd256;

	typedef struct packed {
		logic [X_W-1:0]        x;
		logic signed [Y_W-1:0] y;
		logic                  run_last;
		logic                  buffer_last;
	} point_t;

	// fraction product high part plus integer product, clipped to the x range
	function automatic logic [X_W-1:0] x_sat(input logic [INDEX_BITS-1:0] lo_part,
			input logic [HIPROD_W-1:0] hi_part);
		logic [HIPROD_W:0] sum;
		sum = (HIPROD_W+1)'(lo_part) + (HIPROD_W+1)'(hi_part);
		return (sum > (HIPROD_W+1)'({X_W{1'b1}})) ? {X_W{1'b1}} : sum[X_W-1:0];
	endfunction

	// negate then divide by 2^16 rounding toward zero
	function automatic logic signed [Y_W-1:0] y_conv(input logic signed [YPROD_W-1:0] p);
		logic signed [YPROD_W:0] m;
		logic signed [YPROD_W:0] q;
		m = -$signed({p[YPROD_W-1], p});
		q = m >>> Y_SHIFT;
		if (m < 0 && m[Y_SHIFT-1:0] != '0) begin
			q = q + (YPROD_W+1)'(1);
		end
		return q[Y_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/waveform_minmax_decimator.sv
// ----------------------------------------------------------------------------
// waveform_minmax_decimator
// min/max peak decimation of a signed 16-bit sample stream into plot points
//
// Samples arrive on the input channel, one request per sample, and are cut
// into segments of segment_len samples counted from the start of the buffer
// (a length of zero means 65536). For each segment the block keeps the
// minimum and maximum and the index where each first appears; when the
// segment fills, or on the sample flagged end_of_buffer, it sends one or two
// plot points in time order (a single point when both indices match).
// x_px = index * x_scale_q32 / 2^32 truncated and clipped at 65535,
// y_px = -(value * plot_height) / 65536 rounded toward zero. run_last marks
// the last point of a segment, buffer_last the last point of the buffer, and
// end_of_buffer restarts the sample index at zero. The block takes one sample
// per clock while in_stall is low: the min/max tracker updates at the
// accepting edge, a closed segment is registered, then the multipliers run
// in a second stage, and the finished points go into an 8-entry output
// queue. in_stall rises when queued plus in-flight points leave less than
// room for two more, so the sustained input rate is one sample per cycle as
// long as the output drains one point per cycle; the output port at one
// point per clock is the limit.
// Configuration writes take effect at once and are meant for idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

`include "waveform_minmax_decimator_assert.svh"

module waveform_minmax_decimator (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [wmd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [wmd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// sample requests
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [wmd_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                end_of_buffer,
	// plot point requests
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [wmd_pkg::X_W-1:0]                  x_px,
	output logic signed [wmd_pkg::Y_W-1:0]           y_px,
	output logic                                     run_last,
	output logic                                     buffer_last
);

	localparam int IDX_W = wmd_pkg::INDEX_BITS;
	localparam int SW    = wmd_pkg::SAMPLE_W;

	// configuration registers
	logic [wmd_pkg::SEG_W-1:0]    segment_len_q;
	logic [wmd_pkg::SCALE_W-1:0]  x_scale_q;
	logic [wmd_pkg::HEIGHT_W-1:0] plot_height_q;

	// tracker state
	logic [IDX_W-1:0]          sample_index_q;
	logic [wmd_pkg::SEG_W-1:0] seg_count_q;
	logic signed [SW-1:0]      run_max_q;
	logic signed [SW-1:0]      run_min_q;
	logic [IDX_W-1:0]          max_index_q;
	logic [IDX_W-1:0]          min_index_q;

	// tracker next values
	logic                      in_accept;
	logic                      seg_first;
	logic signed [SW-1:0]      nxt_max;
	logic signed [SW-1:0]      nxt_min;
	logic [IDX_W-1:0]          nxt_imax;
	logic [IDX_W-1:0]          nxt_imin;
	logic [wmd_pkg::SEG_W-1:0] seg_next;
	logic                      close_w;

	// stage 1: closed segment
	logic                 s1_valid_s1;
	logic                 two_s1;
	logic                 eob_s1;
	logic signed [SW-1:0] max_s1;
	logic signed [SW-1:0] min_s1;
	logic [IDX_W-1:0]     imax_s1;
	logic [IDX_W-1:0]     imin_s1;

	// stage 2: products of both extremes
	logic                                 s2_valid_s2;
	logic                                 max_gt_s2;
	logic                                 eq_s2;
	logic                                 eob_s2;
	logic [IDX_W-1:0]                     xlo_max_s2;
	logic [IDX_W-1:0]                     xlo_min_s2;
	logic [wmd_pkg::HIPROD_W-1:0]         xhi_max_s2;
	logic [wmd_pkg::HIPROD_W-1:0]         xhi_min_s2;
	logic signed [wmd_pkg::YPROD_W-1:0]   y_max_s2;
	logic signed [wmd_pkg::YPROD_W-1:0]   y_min_s2;

	logic [IDX_W+wmd_pkg::SCALE_FRAC-1:0] lo_max_w;
	logic [IDX_W+wmd_pkg::SCALE_FRAC-1:0] lo_min_w;

	// point assembly
	wmd_pkg::point_t pt_max;
	wmd_pkg::point_t pt_min;
	wmd_pkg::point_t entry0;
	wmd_pkg::point_t entry1;
	logic            push_two;

	// output queue
	wmd_pkg::point_t             mem_q [wmd_pkg::FIFO_DEPTH];
	logic [wmd_pkg::PTR_W-1:0]   wr_ptr_q;
	logic [wmd_pkg::PTR_W-1:0]   rd_ptr_q;
	logic [wmd_pkg::CNT_W-1:0]   cnt_q;
	logic [wmd_pkg::CNT_W-1:0]   push_n;
	logic [wmd_pkg::CNT_W-1:0]   pend_pts;
	logic [wmd_pkg::CNT_W:0]     occ;
	logic                        pop;

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segment_len_q <= wmd_pkg::SEG_LEN_RESET;
			x_scale_q     <= wmd_pkg::X_SCALE_RESET;
			plot_height_q <= wmd_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wmd_pkg::CFG_SEGMENT_LEN: segment_len_q <= cfg_wdata[wmd_pkg::SEG_W-1:0];
				wmd_pkg::CFG_X_SCALE:     x_scale_q     <= cfg_wdata[wmd_pkg::SCALE_W-1:0];
				wmd_pkg::CFG_PLOT_HEIGHT: plot_height_q <= cfg_wdata[wmd_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// min/max tracker, updated at the accepting edge
	// ------------------------------------------------------------------
	assign in_accept = in_valid && !in_stall;
	assign seg_first = (seg_count_q == '0);
	assign seg_next  = seg_count_q + wmd_pkg::SEG_W'(1);
	// a zero length closes when the count wraps back to zero
	assign close_w   = (seg_next == segment_len_q) || end_of_buffer;

	always_comb begin
		nxt_max  = run_max_q;
		nxt_imax = max_index_q;
		nxt_min  = run_min_q;
		nxt_imin = min_index_q;
		if (seg_first) begin
			nxt_max  = sample;
			nxt_imax = sample_index_q;
			nxt_min  = sample;
			nxt_imin = sample_index_q;
		end else begin
			// strict compares keep the first occurrence on ties
			if (sample > run_max_q) begin
				nxt_max  = sample;
				nxt_imax = sample_index_q;
			end
			if (sample < run_min_q) begin
				nxt_min  = sample;
				nxt_imin = sample_index_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			seg_count_q    <= '0;
			run_max_q      <= '0;
			run_min_q      <= '0;
			max_index_q    <= '0;
			min_index_q    <= '0;
		end else if (in_accept) begin
			sample_index_q <= end_of_buffer ? '0 : sample_index_q + IDX_W'(1);
			seg_count_q    <= close_w ? '0 : seg_next;
			run_max_q      <= nxt_max;
			run_min_q      <= nxt_min;
			max_index_q    <= nxt_imax;
			min_index_q    <= nxt_imin;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: register the closed segment
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			two_s1      <= 1'b0;
		end else begin
			s1_valid_s1 <= in_accept && close_w;
			if (in_accept && close_w) begin
				two_s1 <= (nxt_imax != nxt_imin);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && close_w) begin
			eob_s1  <= end_of_buffer;
			max_s1  <= nxt_max;
			min_s1  <= nxt_min;
			imax_s1 <= nxt_imax;
			imin_s1 <= nxt_imin;
		end
	end

	// ------------------------------------------------------------------
	// stage 2: scale products for both extremes, order flags
	// ------------------------------------------------------------------
	assign lo_max_w = imax_s1 * x_scale_q[wmd_pkg::SCALE_FRAC-1:0];
	assign lo_min_w = imin_s1 * x_scale_q[wmd_pkg::SCALE_FRAC-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
			eq_s2       <= 1'b0;
		end else begin
			s2_valid_s2 <= s1_valid_s1;
			if (s1_valid_s1) begin
				eq_s2 <= !two_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			max_gt_s2  <= (imax_s1 > imin_s1);
			eob_s2     <= eob_s1;
			xlo_max_s2 <= lo_max_w[IDX_W+wmd_pkg::SCALE_FRAC-1:wmd_pkg::SCALE_FRAC];
			xlo_min_s2 <= lo_min_w[IDX_W+wmd_pkg::SCALE_FRAC-1:wmd_pkg::SCALE_FRAC];
			xhi_max_s2 <= imax_s1 * x_scale_q[wmd_pkg::SCALE_W-1:wmd_pkg::SCALE_FRAC];
			xhi_min_s2 <= imin_s1 * x_scale_q[wmd_pkg::SCALE_W-1:wmd_pkg::SCALE_FRAC];
			y_max_s2   <= max_s1 * $signed({1'b0, plot_height_q});
			y_min_s2   <= min_s1 * $signed({1'b0, plot_height_q});
		end
	end

	// ------------------------------------------------------------------
	// point assembly in time order
	// ------------------------------------------------------------------
	always_comb begin
		pt_max.x           = wmd_pkg::x_sat(xlo_max_s2, xhi_max_s2);
		pt_max.y           = wmd_pkg::y_conv(y_max_s2);
		pt_max.run_last    = 1'b0;
		pt_max.buffer_last = 1'b0;
		pt_min.x           = wmd_pkg::x_sat(xlo_min_s2, xhi_min_s2);
		pt_min.y           = wmd_pkg::y_conv(y_min_s2);
		pt_min.run_last    = 1'b0;
		pt_min.buffer_last = 1'b0;

		push_two = !eq_s2;
		// earlier index first; a shared index gives the min point alone
		if (eq_s2 || max_gt_s2) begin
			entry0 = pt_min;
			entry1 = pt_max;
		end else begin
			entry0 = pt_max;
			entry1 = pt_min;
		end
		entry0.run_last    = !push_two;
		entry0.buffer_last = !push_two && eob_s2;
		entry1.run_last    = 1'b1;
		entry1.buffer_last = eob_s2;
	end

	// ------------------------------------------------------------------
	// output queue, up to two pushes and one pop per cycle
	// ------------------------------------------------------------------
	assign push_n    = s2_valid_s2 ? (push_two ? wmd_pkg::CNT_W'(2) : wmd_pkg::CNT_W'(1)) : '0;
	assign pop       = out_valid && !out_stall;
	// points already promised to the queue by stages 1 and 2
	assign pend_pts  = (s1_valid_s1 ? (two_s1 ? wmd_pkg::CNT_W'(2) : wmd_pkg::CNT_W'(1)) : '0)
			+ (s2_valid_s2 ? (eq_s2 ? wmd_pkg::CNT_W'(1) : wmd_pkg::CNT_W'(2)) : '0);
	assign occ       = (wmd_pkg::CNT_W+1)'(cnt_q) + (wmd_pkg::CNT_W+1)'(pend_pts);
	// a new sample may close a segment with two points
	assign in_stall  = occ > (wmd_pkg::CNT_W+1)'(wmd_pkg::FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (s2_valid_s2) begin
			mem_q[wr_ptr_q] <= entry0;
			if (push_two) begin
				mem_q[wr_ptr_q + wmd_pkg::PTR_W'(1)] <= entry1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[wmd_pkg::PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + wmd_pkg::PTR_W'(1);
			end
			cnt_q <= cnt_q + push_n - (pop ? wmd_pkg::CNT_W'(1) : '0);
		end
	end

	assign out_valid   = (cnt_q != '0);
	assign x_px        = mem_q[rd_ptr_q].x;
	assign y_px        = mem_q[rd_ptr_q].y;
	assign run_last    = mem_q[rd_ptr_q].run_last;
	assign buffer_last = mem_q[rd_ptr_q].buffer_last;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`WMD_ASSERT(a_queue_room, occ <= (wmd_pkg::CNT_W+1)'(wmd_pkg::FIFO_DEPTH))
	`WMD_ASSERT_NEXT(a_eob_restart, in_accept && end_of_buffer, (sample_index_q == '0) && (seg_count_q == '0))
	`WMD_ASSERT_NEXT(a_close_to_s1, in_accept && close_w, s1_valid_s1 && (eob_s1 == $past(end_of_buffer)))
	`WMD_ASSERT_NEXT(a_s1_to_s2, s1_valid_s1, s2_valid_s2 && (eq_s2 == !$past(two_s1)))
	`WMD_ASSERT_IMPLY(a_open_seg_no_point, in_accept && !close_w, seg_count_q + wmd_pkg::SEG_W'(1) != segment_len_q)

endmodule

`default_nettype wire
